[src/cbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and helpers for the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int unsigned NodeDepthDefault = 256;
    // Coordinates keep this many fraction bits on the way in and on the way out.
    localparam int unsigned CoordFracBits    = 16;
    localparam int unsigned ParamFracBits    = 16;
    localparam int unsigned ParamWidth       = 20;
    localparam int unsigned CoordWidth       = 32;
    localparam int unsigned CfgIdxWidth      = 2;
    localparam int unsigned CfgDataWidth     = 8;
    localparam int unsigned AccWidth         = 40;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_OPEN_CURVE      = 2'd0,
        CFG_SEGMENT_COUNT   = 2'd1,
        CFG_LAST_NODE_INDEX = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [CoordWidth-1:0] sat32(input logic signed [79:0] v);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        begin
            hi = 80'sd2147483647;
            lo = -80'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7fffffff;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[CoordWidth-1:0];
        end
    endfunction

endpackage : cbs_pkg
`default_nettype wire

[src/cubic_bspline_evaluator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator
// Uniform cubic B-spline evaluator over a banked control node memory.
// ----------------------------------------------------------------------------
// Usage: a request with kind 0 writes one control node into the node memory
// and produces no result. A request with kind 1 evaluates the curve at
// curve_param and produces one result with point and three derivatives.
// The node memory is four banks (address mod 4), so the four nodes of a
// segment are read in the same cycle; one request is taken every cycle
// while no stall holds the pipeline. Node 2, which stands in for every
// index past the last valid one, is also kept in a register so that folded
// taps never compete with a real tap for a bank. The whole pipeline
// advances only when its last stage is empty or taken, so a stall on
// out_ready holds every stage; in_ready drops with it. Loads write the
// memory at their acceptance edge; evaluations read at the next stage, so
// a load followed by an evaluation is seen in order. Reset clears pipeline
// valid bits and the configuration registers (open curve, one segment, last
// node index 3). Node contents are undefined until written. The user must
// change configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator #(
    parameter int unsigned NODE_DEPTH      = cbs_pkg::NodeDepthDefault
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [cbs_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [cbs_pkg::CfgDataWidth-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [7:0]                      node_index,
    input  wire logic signed [31:0]              node_x,
    input  wire logic signed [31:0]              node_y,
    input  wire logic signed [19:0]              curve_param,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [31:0]                   point_x,
    output logic signed [31:0]                   point_y,
    output logic signed [31:0]                   slope_x,
    output logic signed [31:0]                   slope_y,
    output logic signed [31:0]                   bend_x,
    output logic signed [31:0]                   bend_y,
    output logic signed [31:0]                   jerk_x,
    output logic signed [31:0]                   jerk_y
);
    import cbs_pkg::*;

    localparam int unsigned AW = $clog2(NODE_DEPTH);
    localparam int unsigned BD = NODE_DEPTH / 4;
    localparam int unsigned Lat = 8;

    logic       open_reg;
    logic [7:0] segs_reg;
    logic [7:0] last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b1;
            segs_reg <= 8'd1;
            last_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OPEN_CURVE:      open_reg <= cfg_data[0];
                CFG_SEGMENT_COUNT:   segs_reg <= cfg_data;
                CFG_LAST_NODE_INDEX: last_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    logic adv;
    logic [Lat-1:0] vld_reg;
    assign adv      = !vld_reg[Lat-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[Lat-1];

    logic take;
    assign take = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Lat-2:0], take && kind};
    end

    // Stage 0: parameter conditioning and segment split.
    logic signed [19:0] t;
    logic [16:0]        tc;
    logic [24:0]        s;
    always_comb
    begin
        t = curve_param;
        if (open_reg)
        begin
            if (t < 0)
                tc = 17'd0;
            else if (t > 20'sd65536)
                tc = 17'h10000;
            else
                tc = t[16:0];
        end
        else
            tc = {1'b0, t[15:0]};
        s = 25'(tc) * 25'(segs_reg);
    end

    logic [8:0]  seg_reg;
    logic [15:0] frac_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg_reg  <= s[24:16];
            frac_reg <= s[15:0];
        end
    end

    // Node addresses for the four taps, then bank routing. Taps that stay in
    // range are consecutive, so each lands in a different bank.
    logic [AW-1:0] addr [4];
    logic [3:0]    repl;
    logic [AW-1:0] bank_addr [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [9:0] ix;
            ix = 10'(seg_reg) + 10'(k);
            repl[k] = (ix > 10'(last_reg));
            addr[k] = AW'(ix);
        end
        for (int b = 0; b < 4; b++)
        begin
            bank_addr[b] = addr[0];
            for (int k = 0; k < 4; k++)
                if (!repl[k] && addr[k][1:0] == 2'(b))
                    bank_addr[b] = addr[k];
        end
    end

    logic [63:0] bank0 [BD];
    logic [63:0] bank1 [BD];
    logic [63:0] bank2 [BD];
    logic [63:0] bank3 [BD];
    logic [63:0] rd_reg [4];
    logic [1:0]  sel_reg [4];
    logic [63:0] node2_reg;
    logic [63:0] node2_rd_reg;
    logic [3:0]  use2_reg;
    logic [15:0] frac2_reg;
    logic [AW-1:0] waddr;
    assign waddr = AW'(node_index);

    always_ff @(posedge clk)
    begin
        if (take && !kind)
        begin
            unique case (waddr[1:0])
                2'd0: bank0[waddr[AW-1:2]] <= {node_x, node_y};
                2'd1: bank1[waddr[AW-1:2]] <= {node_x, node_y};
                2'd2: bank2[waddr[AW-1:2]] <= {node_x, node_y};
                default: bank3[waddr[AW-1:2]] <= {node_x, node_y};
            endcase
            if (waddr == AW'(2))
                node2_reg <= {node_x, node_y};
        end
        if (adv)
        begin
            rd_reg[0] <= bank0[bank_addr[0][AW-1:2]];
            rd_reg[1] <= bank1[bank_addr[1][AW-1:2]];
            rd_reg[2] <= bank2[bank_addr[2][AW-1:2]];
            rd_reg[3] <= bank3[bank_addr[3][AW-1:2]];
            for (int k = 0; k < 4; k++)
                sel_reg[k] <= addr[k][1:0];
            node2_rd_reg <= node2_reg;
            use2_reg     <= repl;
            frac2_reg    <= frac_reg;
        end
    end

    logic [63:0] p [4];
    always_comb
        for (int k = 0; k < 4; k++)
            p[k] = use2_reg[k] ? node2_rd_reg : rd_reg[sel_reg[k]];

    cbs_horner u_x (
        .clk(clk), .en(adv),
        .p0(p[0][63:32]), .p1(p[1][63:32]), .p2(p[2][63:32]), .p3(p[3][63:32]),
        .frac(frac2_reg),
        .point(point_x), .slope(slope_x), .bend(bend_x), .jerk(jerk_x)
    );
    cbs_horner u_y (
        .clk(clk), .en(adv),
        .p0(p[0][31:0]), .p1(p[1][31:0]), .p2(p[2][31:0]), .p3(p[3][31:0]),
        .frac(frac2_reg),
        .point(point_y), .slope(slope_y), .bend(bend_y), .jerk(jerk_y)
    );

    // The output stalls as a whole: a held result keeps its values.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !kind |=> !vld_reg[0])
        else $error("load produced a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

endmodule : cubic_bspline_evaluator
`default_nettype wire

[src/cbs_horner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_horner
// Horner pipeline for one coordinate: point, slope, bend and jerk.
// ----------------------------------------------------------------------------
module cbs_horner (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [31:0]       p0,
    input  wire logic signed [31:0]       p1,
    input  wire logic signed [31:0]       p2,
    input  wire logic signed [31:0]       p3,
    input  wire logic [15:0]              frac,
    output logic signed [31:0]            point,
    output logic signed [31:0]            slope,
    output logic signed [31:0]            bend,
    output logic signed [31:0]            jerk
);
    import cbs_pkg::*;

    // Stage 1: coefficients. Stages 2 to 4: one Horner step each (multiply then
    // add). Stage 5 clamps the scaled point and halves it, stage 6 divides the
    // half by three with a reciprocal multiply.
    localparam logic [33:0] DivThreeMul = 34'd11453246123;

    logic signed [39:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic signed [39:0] d1_reg, d2_reg, e1_reg;
    logic [15:0]        f1_reg;

    // stage 2
    logic signed [79:0] hp_reg, hd_reg, he_reg;
    logic signed [39:0] s2_c1_reg, s2_c2_reg, s2_c3_reg, s2_d1_reg, s2_d2_reg, s2_e1_reg;
    logic signed [39:0] s2_j_reg;
    logic [15:0]        f2_reg;
    // stage 3
    logic signed [79:0] hp3_reg, hd3_reg;
    logic signed [39:0] s3_c2_reg, s3_c3_reg, s3_d2_reg;
    logic signed [31:0] b3_reg, j3_reg;
    logic [15:0]        f3_reg;
    // stage 4
    logic signed [79:0] hp4_reg;
    logic signed [39:0] s4_c3_reg;
    logic signed [31:0] sl4_reg, b4_reg, j4_reg;
    // stage 5
    logic [33:0]        y5_reg;
    logic signed [31:0] sl5_reg, b5_reg, j5_reg;

    logic signed [39:0] a0, a1, a2, a3;
    assign a0 = 40'(p0);
    assign a1 = 40'(p1);
    assign a2 = 40'(p2);
    assign a3 = 40'(p3);

    logic signed [39:0] n1, n2, n3, n4;
    logic signed [79:0] pr, pc, half;
    logic [67:0]        prod;

    always_comb
    begin
        n1 = s2_c1_reg + 40'(hp_reg >>> ParamFracBits);
        n2 = s2_d1_reg + 40'(hd_reg >>> ParamFracBits);
        n3 = s2_e1_reg + 40'(he_reg >>> ParamFracBits);
        n4 = s3_c2_reg + 40'(hp3_reg >>> ParamFracBits);
        pr = 80'(s4_c3_reg) + (hp4_reg >>> ParamFracBits);
        // Anything outside six times the 32-bit range saturates anyway.
        if (pr > 80'sd12884901887)
            pc = 80'sd12884901887;
        else if (pr < -80'sd12884901888)
            pc = -80'sd12884901888;
        else
            pc = pr;
        half = pc >>> 1;
    end

    // The biased half lies in [0, 2^34), where the reciprocal gives the exact floor.
    assign prod = 68'(y5_reg) * 68'(DivThreeMul);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= -a0 + 3*a1 - 3*a2 + a3;
            c1_reg <= 3*a0 - 6*a1 + 3*a2;
            c2_reg <= -3*a0 + 3*a2;
            c3_reg <= a0 + 4*a1 + a2;
            d1_reg <= 2*a0 - 4*a1 + 2*a2;
            d2_reg <= a2 - a0;
            e1_reg <= a0 - 2*a1 + a2;
            f1_reg <= frac;

            hp_reg    <= c0_reg * $signed({1'b0, f1_reg});
            hd_reg    <= c0_reg * $signed({1'b0, f1_reg});
            he_reg    <= c0_reg * $signed({1'b0, f1_reg});
            s2_c1_reg <= c1_reg;
            s2_c2_reg <= c2_reg;
            s2_c3_reg <= c3_reg;
            s2_d1_reg <= d1_reg;
            s2_d2_reg <= d2_reg;
            s2_e1_reg <= e1_reg;
            s2_j_reg  <= c0_reg;
            f2_reg    <= f1_reg;

            hp3_reg   <= n1 * $signed({1'b0, f2_reg});
            hd3_reg   <= n2 * $signed({1'b0, f2_reg});
            b3_reg    <= sat32(80'(n3));
            j3_reg    <= sat32(80'(s2_j_reg));
            s3_c2_reg <= s2_c2_reg;
            s3_c3_reg <= s2_c3_reg;
            s3_d2_reg <= s2_d2_reg;
            f3_reg    <= f2_reg;

            hp4_reg   <= n4 * $signed({1'b0, f3_reg});
            sl4_reg   <= sat32(80'((s3_d2_reg + 40'(hd3_reg >>> ParamFracBits)) >>> 1));
            s4_c3_reg <= s3_c3_reg;
            b4_reg    <= b3_reg;
            j4_reg    <= j3_reg;

            y5_reg    <= 34'(half + 80'sd6442450944);
            sl5_reg   <= sl4_reg;
            b5_reg    <= b4_reg;
            j5_reg    <= j4_reg;

            // Removing the bias of 2^31 flips the top bit of the quotient.
            point <= {~prod[66], prod[65:35]};
            slope <= sl5_reg;
            bend  <= b5_reg;
            jerk  <= j5_reg;
        end
    end

endmodule : cbs_horner
`default_nettype wire
